/* hw/rtl/cnai_pkg.sv */
// shared constants, types and codes for the circular nearest azimuth index
`timescale 1ns / 1ps
package cnai_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int ANGLE_BITS  = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int BEAM_W      = 9;

    typedef logic [ANGLE_BITS-1:0] t_angle;
    typedef logic [BEAM_W-1:0]     t_beam;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef struct packed {
        t_beam  beam;
        t_angle angle;
    } t_entry;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

endpackage

/* hw/rtl/circular_nearest_azimuth_index.sv */
// top level: sorted azimuth table with nearest-on-the-circle lookup
`timescale 1ns / 1ps
// usage
//   command channel: raise start with i_operation, i_azimuth, i_beam_index;
//   the command transfers at a clock edge with start high and busy low
//   result channel: o_done is high for exactly one cycle with o_found_index,
//   o_found_azimuth and o_status; it cannot be held off by the receiver
//   every command gives exactly one result
// command flow (n = entries held, lower bound search of at most ceil(log2(n+1)) steps)
//   clear and unused codes: result in the cycle after the transfer
//   query: search, neighbour reads, compare; empty table: result in the cycle after the transfer
//   insert: search, duplicate and full checks, entries above the slot moved up one per cycle, then the write
//   busy stays high until the result cycle, so one command at a time
// what sets the rate
//   one single-port-read table memory (read data registered): each lower
//   bound step is an address state and a compare state, and an insert moves
//   entries one per cycle as a read/write pipeline
// reset
//   synchronous, active low; empties the table (entry count to zero);
//   the memory itself is not cleared, entries past the count are never used
module circular_nearest_azimuth_index
    import cnai_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_azimuth,
    input  logic [8:0]  i_beam_index,
    output logic        o_done,
    output logic [8:0]  o_found_index,
    output logic [15:0] o_found_azimuth,
    output logic [1:0]  o_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_SCMP, S_POST, S_DUPCHK, S_SHIFT, S_PLACE,
        S_QLAST, S_QFIRST, S_QP, S_QPREV
    } t_state;

    t_state r_state;
    logic [1:0] r_op;
    t_angle r_az;
    t_beam  r_beam;
    t_cnt   r_cnt, r_lo, r_hi, r_k;
    t_entry r_cand;

    // table memory
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;
    t_addr  rd_addr, wr_addr;
    t_entry wr_data;
    logic   wr_en;

    t_cnt   mid;
    t_cnt   n_lo, n_hi;
    t_angle nr_first, nr_second;
    logic   take_first;

    assign mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign busy = (r_state != S_IDLE);

    // one lower bound step
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (r_rd_data.angle < r_az) begin
            n_lo = mid + t_cnt'(1);
        end else begin
            n_hi = mid;
        end
    end

    // memory addressing per state
    always_comb begin
        rd_addr = mid[ADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_k[ADDR_W-1:0];
        wr_data = r_rd_data;
        case (r_state)
            S_POST: begin
                if (r_op == OP_QUERY && (r_lo == r_cnt || r_lo == t_cnt'(0))) begin
                    rd_addr = t_addr'(r_cnt - t_cnt'(1));
                end else begin
                    rd_addr = r_lo[ADDR_W-1:0];
                end
            end
            S_DUPCHK: rd_addr = t_addr'(r_cnt - t_cnt'(1));
            S_SHIFT: begin
                wr_en   = 1'b1;
                rd_addr = t_addr'(r_k - t_cnt'(2));
            end
            S_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = r_lo[ADDR_W-1:0];
                wr_data = '{beam: r_beam, angle: r_az};
            end
            S_QLAST: rd_addr = '0;
            S_QP:    rd_addr = t_addr'(r_lo - t_cnt'(1));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // candidate pair for the final compare
    always_comb begin
        if (r_state == S_QFIRST) begin
            nr_first  = r_cand.angle;
            nr_second = r_rd_data.angle;
        end else begin
            nr_first  = r_rd_data.angle;
            nr_second = r_cand.angle;
        end
    end

    cnai_nearer u_nearer (
        .i_az        (r_az),
        .i_first     (nr_first),
        .i_second    (nr_second),
        .o_take_first(take_first)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op            <= i_operation;
                        r_az            <= t_angle'(i_azimuth);
                        r_beam          <= i_beam_index;
                        r_lo            <= '0;
                        r_hi            <= r_cnt;
                        o_found_index   <= '0;
                        o_found_azimuth <= '0;
                        o_status        <= ST_OK;
                        case (i_operation)
                            OP_CLEAR: begin
                                r_cnt  <= '0;
                                o_done <= 1'b1;
                            end
                            OP_INSERT: r_state <= S_SEARCH;
                            OP_QUERY: begin
                                if (r_cnt == t_cnt'(0)) begin
                                    o_status <= ST_EMPTY;
                                    o_done   <= 1'b1;
                                end else begin
                                    r_state <= S_SEARCH;
                                end
                            end
                            default: o_done <= 1'b1;
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (r_lo < r_hi) begin
                        r_state <= S_SCMP;
                    end else begin
                        r_state <= S_POST;
                    end
                end
                S_SCMP: begin
                    r_lo    <= n_lo;
                    r_hi    <= n_hi;
                    r_state <= S_SEARCH;
                end
                S_POST: begin
                    if (r_op == OP_QUERY) begin
                        if (r_lo == r_cnt || r_lo == t_cnt'(0)) begin
                            r_state <= S_QLAST;
                        end else begin
                            r_state <= S_QP;
                        end
                    end else if (r_lo < r_cnt) begin
                        r_state <= S_DUPCHK;
                    end else if (r_cnt == t_cnt'(TABLE_DEPTH)) begin
                        o_status <= ST_FULL;
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_DUPCHK: begin
                    // lower bound entry is below the count here, so unless duplicate or full a shift is needed
                    if (r_rd_data.angle == r_az) begin
                        o_status <= ST_DUP;
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_cnt == t_cnt'(TABLE_DEPTH)) begin
                        o_status <= ST_FULL;
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_k     <= r_cnt;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_k - t_cnt'(1) == r_lo) begin
                        r_state <= S_PLACE;
                    end else begin
                        r_k <= r_k - t_cnt'(1);
                    end
                end
                S_PLACE: begin
                    r_cnt   <= r_cnt + t_cnt'(1);
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_QLAST: begin
                    r_cand  <= r_rd_data;
                    r_state <= S_QFIRST;
                end
                S_QFIRST: begin
                    if (take_first) begin
                        o_found_index   <= r_cand.beam;
                        o_found_azimuth <= 16'(r_cand.angle);
                    end else begin
                        o_found_index   <= r_rd_data.beam;
                        o_found_azimuth <= 16'(r_rd_data.angle);
                    end
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_QP: begin
                    if (r_rd_data.angle == r_az) begin
                        o_found_index   <= r_rd_data.beam;
                        o_found_azimuth <= 16'(r_rd_data.angle);
                        o_done          <= 1'b1;
                        r_state         <= S_IDLE;
                    end else begin
                        r_cand  <= r_rd_data;
                        r_state <= S_QPREV;
                    end
                end
                S_QPREV: begin
                    if (take_first) begin
                        o_found_index   <= r_rd_data.beam;
                        o_found_azimuth <= 16'(r_rd_data.angle);
                    end else begin
                        o_found_index   <= r_cand.beam;
                        o_found_azimuth <= 16'(r_cand.angle);
                    end
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/cnai_nearer.sv */
// circular distance compare of two candidate angles against a query angle
`timescale 1ns / 1ps
module cnai_nearer
    import cnai_pkg::*;
(
    input  t_angle i_az,
    input  t_angle i_first,
    input  t_angle i_second,
    output logic   o_take_first
);

    t_angle d1, e1, m1, d2, e2, m2;

    always_comb begin
        d1 = i_first - i_az;
        e1 = t_angle'(0) - d1;
        m1 = (d1 < e1) ? d1 : e1;
        d2 = i_second - i_az;
        e2 = t_angle'(0) - d2;
        m2 = (d2 < e2) ? d2 : e2;
        // tie goes to the second candidate
        o_take_first = (m1 < m2);
    end

endmodule
